### sv/i2cmbr_pkg.sv
// types and constants shared by the i2c master burst read engine
// no dependencies; used by i2cmbr_step and i2c_master_burst_read
package i2cmbr_pkg;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_START,
      PH_ADDR,
      PH_AACK,
      PH_READ,
      PH_MACK,
      PH_STOP
   } phase_type;

   // control and data state carried from slot to slot
   typedef struct packed {
      phase_type  phase;
      logic [1:0] slot;
      logic [2:0] bit_cnt;
      logic [7:0] shift;
      logic       error;
   } state_type;

   typedef struct packed {
      logic start_request;
      logic sda_sample;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_pull_low;
      logic       busy_res;
      logic       byte_valid;
      logic [7:0] data_byte;
      logic [3:0] byte_index;
      logic       last_byte;
      logic       address_nack;
   } rsp_type;

   localparam logic [1:0] CSR_SLAVE_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_READ_COUNT    = 2'd1;

   localparam logic [6:0] SLAVE_ADDRESS_RST = 7'd80;
   localparam logic [4:0] READ_COUNT_RST    = 5'd9;

   localparam logic       ADDR_READ_BIT     = 1'b1;
   localparam logic [1:0] SLOT_SAMPLE       = 2'd2;
   localparam logic [1:0] SLOT_LAST         = 2'd3;
   localparam logic [2:0] BIT_LAST          = 3'd7;

endpackage

### sv/i2cmbr_step.sv
// one bus slot of the i2c read sequencer: next state and pin/status outputs
// depends on i2cmbr_pkg
module i2cmbr_step #(
   parameter int MAX_READ_BYTES = 16
) (
   input  i2cmbr_pkg::state_type                 state_cur,
   input  logic [$clog2(MAX_READ_BYTES + 1)-1:0] byte_cnt_cur,
   input  logic [6:0]                            slave_address,
   input  logic [4:0]                            read_count,
   input  i2cmbr_pkg::req_type                   req,
   output i2cmbr_pkg::state_type                 state_nxt,
   output logic [$clog2(MAX_READ_BYTES + 1)-1:0] byte_cnt_nxt,
   output i2cmbr_pkg::rsp_type                   rsp
);

   localparam int CNT_W = $clog2(MAX_READ_BYTES + 1);
   localparam int CMP_W = ((CNT_W > 5) ? CNT_W : 5) + 1;
   localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_READ_BYTES);

   i2cmbr_pkg::state_type st;
   logic [CNT_W-1:0]      byte_cnt;
   logic [CMP_W-1:0]      count_ext;
   logic [CMP_W-1:0]      eff_count;
   logic [CMP_W-1:0]      byte_ext;
   logic                  last;
   logic [7:0]            addr_byte;
   logic                  end_slot;
   logic                  scl;
   logic                  pull;

   // out-of-range byte counts are clamped to 1..MAX_READ_BYTES
   assign count_ext = CMP_W'(read_count);
   assign eff_count = (read_count == 5'd0) ? CMP_W'(1) :
                      ((count_ext > MAX_CMP) ? MAX_CMP : count_ext);
   assign addr_byte = {slave_address, i2cmbr_pkg::ADDR_READ_BIT};

   always_comb begin
      st       = state_cur;
      byte_cnt = byte_cnt_cur;
      scl      = 1'b1;
      pull     = 1'b0;
      rsp      = '0;

      // a start request from idle drives START slot 0 in the same slot
      if (st.phase == i2cmbr_pkg::PH_IDLE && req.start_request) begin
         st.phase   = i2cmbr_pkg::PH_START;
         st.slot    = 2'd0;
         st.bit_cnt = 3'd0;
         st.shift   = 8'd0;
         st.error   = 1'b0;
         byte_cnt   = '0;
      end

      end_slot = (st.slot == i2cmbr_pkg::SLOT_LAST);
      byte_ext = CMP_W'(byte_cnt);
      last     = ((byte_ext + CMP_W'(1)) >= eff_count);

      case (st.phase)
         i2cmbr_pkg::PH_START: begin
            scl  = (st.slot != i2cmbr_pkg::SLOT_LAST);
            pull = (st.slot != 2'd0);
            if (end_slot) st.phase = i2cmbr_pkg::PH_ADDR;
         end
         i2cmbr_pkg::PH_ADDR: begin
            scl  = st.slot[1];
            pull = ~addr_byte[3'd7 - st.bit_cnt];
            if (end_slot) begin
               if (st.bit_cnt == i2cmbr_pkg::BIT_LAST) begin
                  st.phase   = i2cmbr_pkg::PH_AACK;
                  st.bit_cnt = 3'd0;
               end else begin
                  st.bit_cnt = st.bit_cnt + 3'd1;
               end
            end
         end
         i2cmbr_pkg::PH_AACK: begin
            scl = st.slot[1];
            if (st.slot == i2cmbr_pkg::SLOT_SAMPLE) st.error = req.sda_sample;
            if (end_slot) begin
               st.phase = st.error ? i2cmbr_pkg::PH_STOP : i2cmbr_pkg::PH_READ;
            end
         end
         i2cmbr_pkg::PH_READ: begin
            scl = st.slot[1];
            if (st.slot == i2cmbr_pkg::SLOT_SAMPLE) begin
               st.shift = {st.shift[6:0], req.sda_sample};
               if (st.bit_cnt == i2cmbr_pkg::BIT_LAST) begin
                  rsp.byte_valid = 1'b1;
                  rsp.data_byte  = st.shift;
                  rsp.byte_index = byte_ext[3:0];
                  rsp.last_byte  = last;
               end
            end
            if (end_slot) begin
               if (st.bit_cnt == i2cmbr_pkg::BIT_LAST) begin
                  st.phase   = i2cmbr_pkg::PH_MACK;
                  st.bit_cnt = 3'd0;
               end else begin
                  st.bit_cnt = st.bit_cnt + 3'd1;
               end
            end
         end
         i2cmbr_pkg::PH_MACK: begin
            // ack every byte but the last, which gets a nack pulse
            scl  = st.slot[1];
            pull = ~last;
            if (end_slot) begin
               byte_cnt = CNT_W'(byte_ext + CMP_W'(1));
               st.phase = last ? i2cmbr_pkg::PH_STOP : i2cmbr_pkg::PH_READ;
            end
         end
         i2cmbr_pkg::PH_STOP: begin
            scl  = (st.slot != 2'd0);
            pull = (st.slot != i2cmbr_pkg::SLOT_LAST);
            if (end_slot) st.phase = i2cmbr_pkg::PH_IDLE;
         end
         default: begin
            st.phase = i2cmbr_pkg::PH_IDLE;
         end
      endcase

      rsp.scl_level    = scl;
      rsp.sda_pull_low = pull;
      rsp.busy_res     = ~scl | pull | (st.slot != 2'd0) |
                         (st.phase != i2cmbr_pkg::PH_IDLE);
      rsp.address_nack = st.error;

      st.slot = (st.phase == i2cmbr_pkg::PH_IDLE) ? 2'd0 : (st.slot + 2'd1);

      state_nxt    = st;
      byte_cnt_nxt = byte_cnt;
   end

endmodule

### sv/i2c_master_burst_read.sv
// i2c master burst read engine: handshake pipeline, registers, config port
// depends on i2cmbr_pkg and i2cmbr_step
//
// each beat on req is one bus timing slot carrying a start request and the
// sampled sda level; each slot gives exactly one beat on rsp with the scl
// level, sda drive, busy, nack status and any byte finished in that slot.
// a bit cell is four slots, so one byte plus its ack takes 36 slots.
// csr writes set slave_address (index 0) and read_count (index 1); csr_ready
// is always high and writes to other indexes are dropped.
// a req beat lands in the input register and is stepped through the
// sequencer into the result register, which drives rsp_valid and rsp_data.
// throughput: one beat per cycle; the input and result registers form a
// two-deep pipeline, so req_ready stays high while rsp is taken each cycle.
// when rsp stalls, the result register holds and the input register fills;
// req_ready then drops until rsp_ready returns.
// reset clears both pipeline valids, puts the sequencer in idle and loads
// slave_address 80 and read_count 9.
module i2c_master_burst_read #(
   parameter int MAX_READ_BYTES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  i2cmbr_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output i2cmbr_pkg::rsp_type rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [6:0]          csr_wdata
);

   localparam int CNT_W = $clog2(MAX_READ_BYTES + 1);

   logic                  in_valid_ff, in_valid_in;
   i2cmbr_pkg::req_type   in_data_ff,  in_data_in;
   logic                  out_valid_ff, out_valid_in;
   i2cmbr_pkg::rsp_type   out_data_ff,  out_data_in;
   i2cmbr_pkg::state_type state_ff,     state_in;
   logic [CNT_W-1:0]      byte_cnt_ff,  byte_cnt_in;
   logic [6:0]            slave_address_ff, slave_address_in;
   logic [4:0]            read_count_ff,    read_count_in;

   i2cmbr_pkg::state_type state_step;
   logic [CNT_W-1:0]      byte_cnt_step;
   i2cmbr_pkg::rsp_type   rsp_step;
   logic                  advance;

   i2cmbr_step #(
      .MAX_READ_BYTES(MAX_READ_BYTES)
   ) u_step (
      .state_cur    (state_ff),
      .byte_cnt_cur (byte_cnt_ff),
      .slave_address(slave_address_ff),
      .read_count   (read_count_ff),
      .req          (in_data_ff),
      .state_nxt    (state_step),
      .byte_cnt_nxt (byte_cnt_step),
      .rsp          (rsp_step)
   );

   // the held beat moves on when the result register is free or drains
   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      state_in     = state_ff;
      byte_cnt_in  = byte_cnt_ff;

      if (advance) begin
         in_valid_in  = 1'b0;
         out_valid_in = 1'b1;
         out_data_in  = rsp_step;
         state_in     = state_step;
         byte_cnt_in  = byte_cnt_step;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end

      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end
   end

   always_comb begin
      slave_address_in = slave_address_ff;
      read_count_in    = read_count_ff;
      if (csr_valid) begin
         case (csr_index)
            i2cmbr_pkg::CSR_SLAVE_ADDRESS: slave_address_in = csr_wdata;
            i2cmbr_pkg::CSR_READ_COUNT:    read_count_in    = csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         state_ff         <= '{phase: i2cmbr_pkg::PH_IDLE, slot: 2'd0,
                               bit_cnt: 3'd0, shift: 8'd0, error: 1'b0};
         byte_cnt_ff      <= '0;
         slave_address_ff <= i2cmbr_pkg::SLAVE_ADDRESS_RST;
         read_count_ff    <= i2cmbr_pkg::READ_COUNT_RST;
      end else begin
         in_valid_ff      <= in_valid_in;
         out_valid_ff     <= out_valid_in;
         state_ff         <= state_in;
         byte_cnt_ff      <= byte_cnt_in;
         slave_address_ff <= slave_address_in;
         read_count_ff    <= read_count_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

endmodule

### tb/i2c_master_burst_read_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the i2c master burst read engine
// depends on i2cmbr_pkg and i2c_master_burst_read; drives slots, checks every rsp beat
module i2c_master_burst_read_test;

   localparam int BURST_MAX      = 16;
   localparam int ITEM_TARGET    = 1350;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int CSR_SETTLE     = 4;
   localparam int END_SETTLE     = 8;
   localparam logic [1:0] CSR_UNMAPPED_LO = 2'd2;
   localparam logic [1:0] CSR_UNMAPPED_HI = 2'd3;

   typedef struct {
      bit                  is_csr;
      logic [1:0]          idx;
      logic [6:0]          wdata;
      logic                start;
      logic                sda;
      int                  reps;
      bit                  typed;
      i2cmbr_pkg::rsp_type want;
   } plan_row_type;

   logic                clock;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   i2cmbr_pkg::req_type req_data  = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   i2cmbr_pkg::rsp_type rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [1:0]          csr_index = '0;
   logic [6:0]          csr_wdata = '0;

   // engine state as the checker sees it
   i2cmbr_pkg::phase_type ph        = i2cmbr_pkg::PH_IDLE;
   logic [1:0]            slot      = '0;
   int                    bitc      = 0;
   int                    bytec     = 0;
   logic [7:0]            shreg     = '0;
   logic                  err       = 1'b0;
   logic [6:0]            cfg_addr  = i2cmbr_pkg::SLAVE_ADDRESS_RST;
   logic [4:0]            cfg_count = i2cmbr_pkg::READ_COUNT_RST;

   i2cmbr_pkg::rsp_type pending[$];
   plan_row_type        plan[$];

   int errors     = 0;
   int beats      = 0;
   int sent       = 0;
   int bytes_rx   = 0;
   int txn_count  = 0;
   int nack_count = 0;
   int csr_writes = 0;
   int req_gap    = 1;
   int req_calm   = 0;
   int rsp_stall  = 0;
   int rsp_calm   = 0;
   int quiet      = 0;

   i2c_master_burst_read #(
      .MAX_READ_BYTES(BURST_MAX)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // advance the engine by one slot and return what the bus should show
   function automatic i2cmbr_pkg::rsp_type slot_predict(input logic start, input logic sda);
      i2cmbr_pkg::rsp_type r;
      logic [1:0]          s;
      logic                end_slot;
      logic                last;
      logic                scl;
      logic                pull;
      logic [7:0]          abyte;
      int                  n;
      r    = '0;
      scl  = 1'b1;
      pull = 1'b0;
      if (ph == i2cmbr_pkg::PH_IDLE && start) begin
         ph    = i2cmbr_pkg::PH_START;
         slot  = '0;
         bitc  = 0;
         bytec = 0;
         shreg = '0;
         err   = 1'b0;
         txn_count++;
      end
      s        = slot;
      end_slot = (s == i2cmbr_pkg::SLOT_LAST);
      n        = (cfg_count == 0) ? 1 : ((cfg_count > BURST_MAX) ? BURST_MAX : int'(cfg_count));
      case (ph)
         i2cmbr_pkg::PH_START: begin
            scl  = (s < 2'd3);
            pull = (s >= 2'd1);
            if (end_slot) ph = i2cmbr_pkg::PH_ADDR;
         end
         i2cmbr_pkg::PH_ADDR: begin
            abyte = {cfg_addr, i2cmbr_pkg::ADDR_READ_BIT};
            scl   = (s >= i2cmbr_pkg::SLOT_SAMPLE);
            pull  = !abyte[3'(7 - bitc)];
            if (end_slot) begin
               if (bitc >= 7) begin
                  ph   = i2cmbr_pkg::PH_AACK;
                  bitc = 0;
               end else bitc++;
            end
         end
         i2cmbr_pkg::PH_AACK: begin
            scl = (s >= i2cmbr_pkg::SLOT_SAMPLE);
            if (s == i2cmbr_pkg::SLOT_SAMPLE) err = sda;
            if (end_slot) begin
               ph = err ? i2cmbr_pkg::PH_STOP : i2cmbr_pkg::PH_READ;
               if (err) nack_count++;
            end
         end
         i2cmbr_pkg::PH_READ: begin
            scl = (s >= i2cmbr_pkg::SLOT_SAMPLE);
            if (s == i2cmbr_pkg::SLOT_SAMPLE) begin
               shreg = {shreg[6:0], sda};
               if (bitc >= 7) begin
                  r.byte_valid = 1'b1;
                  r.data_byte  = shreg;
                  r.byte_index = bytec[3:0];
                  r.last_byte  = (bytec + 1 >= n);
               end
            end
            if (end_slot) begin
               if (bitc >= 7) begin
                  ph   = i2cmbr_pkg::PH_MACK;
                  bitc = 0;
               end else bitc++;
            end
         end
         i2cmbr_pkg::PH_MACK: begin
            last = (bytec + 1 >= n);
            scl  = (s >= i2cmbr_pkg::SLOT_SAMPLE);
            pull = !last;
            if (end_slot) begin
               bytec++;
               ph = last ? i2cmbr_pkg::PH_STOP : i2cmbr_pkg::PH_READ;
            end
         end
         i2cmbr_pkg::PH_STOP: begin
            scl  = (s >= 2'd1);
            pull = (s < 2'd3);
            if (end_slot) ph = i2cmbr_pkg::PH_IDLE;
         end
         default: ph = i2cmbr_pkg::PH_IDLE;
      endcase
      r.scl_level    = scl;
      r.sda_pull_low = pull;
      r.busy_res     = (!scl || pull || s != 2'd0 || ph != i2cmbr_pkg::PH_IDLE);
      r.address_nack = err;
      slot = (ph == i2cmbr_pkg::PH_IDLE) ? 2'd0 : s + 2'd1;
      return r;
   endfunction

   function automatic i2cmbr_pkg::rsp_type mk_rsp(input logic scl, input logic pull,
                                                  input logic busy, input logic nack);
      i2cmbr_pkg::rsp_type r;
      r              = '0;
      r.scl_level    = scl;
      r.sda_pull_low = pull;
      r.busy_res     = busy;
      r.address_nack = nack;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 1;
      if (r < 85) return $urandom_range(2, 4);
      if (r < 97) return $urandom_range(5, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int next_req_gap();
      if (req_calm > 0) begin
         req_calm--;
         return 0;
      end
      if ($urandom_range(0, 199) == 0) begin
         req_calm = $urandom_range(40, 250);
         return 0;
      end
      if ($urandom_range(0, 2) != 0) return 0;
      return pick_gap();
   endfunction

   function automatic logic [6:0] pick_count();
      logic [6:0] w;
      int         r;
      w = 7'($urandom_range(0, 127));
      r = $urandom_range(0, 99);
      if (r < 70)      w[4:0] = 5'($urandom_range(0, 3));
      else if (r < 85) w[4:0] = 5'($urandom_range(4, 8));
      else if (r < 95) w[4:0] = 5'($urandom_range(9, 16));
      else             w[4:0] = 5'($urandom_range(17, 31));
      return w;
   endfunction

   function automatic logic [6:0] pick_addr();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 7'h00;
      if (r < 30) return 7'h7f;
      return 7'($urandom_range(0, 127));
   endfunction

   function automatic void add_csr(input logic [1:0] idx, input logic [6:0] wdata);
      plan_row_type row;
      row        = '{default: 0};
      row.is_csr = 1'b1;
      row.idx    = idx;
      row.wdata  = wdata;
      plan.push_back(row);
   endfunction

   function automatic void add_slots(input logic start, input logic sda, input int reps,
                                     input bit typed, input i2cmbr_pkg::rsp_type want);
      plan_row_type row;
      row       = '{default: 0};
      row.start = start;
      row.sda   = sda;
      row.reps  = reps;
      row.typed = typed;
      row.want  = want;
      plan.push_back(row);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (errors < 100)
         $display("tb: mismatch on %s at beat %0d: got %0h want %0h", what, beats, got, want);
      errors++;
   endtask

   task automatic check_slot(input i2cmbr_pkg::rsp_type got);
      i2cmbr_pkg::rsp_type want;
      if (got.byte_valid) bytes_rx++;
      if (pending.size() == 0) begin
         report_mismatch("unexpected beat", int'(got), 0);
      end else begin
         want = pending.pop_front();
         if (got.scl_level !== want.scl_level)
            report_mismatch("scl_level", got.scl_level, want.scl_level);
         if (got.sda_pull_low !== want.sda_pull_low)
            report_mismatch("sda_pull_low", got.sda_pull_low, want.sda_pull_low);
         if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", got.busy_res, want.busy_res);
         if (got.byte_valid !== want.byte_valid)
            report_mismatch("byte_valid", got.byte_valid, want.byte_valid);
         if (got.data_byte !== want.data_byte)
            report_mismatch("data_byte", got.data_byte, want.data_byte);
         if (got.byte_index !== want.byte_index)
            report_mismatch("byte_index", got.byte_index, want.byte_index);
         if (got.last_byte !== want.last_byte)
            report_mismatch("last_byte", got.last_byte, want.last_byte);
         if (got.address_nack !== want.address_nack)
            report_mismatch("address_nack", got.address_nack, want.address_nack);
      end
      beats++;
   endtask

   // valid stays high across back-to-back beats; it is only lowered for a gap
   task automatic send_slot(input logic start, input logic sda, input bit typed,
                            input i2cmbr_pkg::rsp_type want);
      i2cmbr_pkg::req_type item;
      i2cmbr_pkg::rsp_type got;
      item.start_request = start;
      item.sda_sample    = sda;
      if (req_gap > 0) repeat (req_gap) @(posedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      got = slot_predict(start, sda);
      pending.push_back(typed ? want : got);
      sent++;
      req_gap = next_req_gap();
      if (req_gap > 0) req_valid <= 1'b0;
   endtask

   task automatic hold_req();
      if (req_gap == 0) begin
         req_valid <= 1'b0;
         req_gap = 1;
      end
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [6:0] value);
      hold_req();
      while (pending.size() != 0) @(posedge clock);
      repeat (CSR_SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         i2cmbr_pkg::CSR_SLAVE_ADDRESS: cfg_addr = value;
         i2cmbr_pkg::CSR_READ_COUNT:    cfg_count = value[4:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_slot(rsp_data);
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else if (rsp_calm > 0) begin
         rsp_calm--;
         rsp_ready <= 1'b1;
      end else if ($urandom_range(0, 199) == 0) begin
         rsp_calm = $urandom_range(40, 250);
         rsp_ready <= 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
         rsp_stall = pick_gap() - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      logic start;
      logic sda;
      bit   noisy;
      bit   cut_short;
      int   burst;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      add_csr(CSR_UNMAPPED_LO, 7'h7f);
      add_csr(CSR_UNMAPPED_HI, 7'h55);
      add_slots(1'b0, 1'b0, 1, 1'b1, mk_rsp(1'b1, 1'b0, 1'b0, 1'b0));
      add_slots(1'b0, 1'b1, 1, 1'b1, mk_rsp(1'b1, 1'b0, 1'b0, 1'b0));
      add_slots(1'b1, 1'b1, 1, 1'b1, mk_rsp(1'b1, 1'b0, 1'b1, 1'b0));
      // start held while busy must be ignored
      add_slots(1'b1, 1'b0, 3, 1'b0, '0);
      add_slots(1'b0, 1'b1, 32, 1'b0, '0);
      // slave leaves sda high on the address ack
      add_slots(1'b0, 1'b1, 4, 1'b0, '0);
      add_slots(1'b0, 1'b0, 4, 1'b0, '0);
      add_slots(1'b0, 1'b0, 1, 1'b1, mk_rsp(1'b1, 1'b0, 1'b0, 1'b1));
      // zero byte count behaves as one
      add_csr(i2cmbr_pkg::CSR_READ_COUNT, 7'd0);
      add_csr(i2cmbr_pkg::CSR_SLAVE_ADDRESS, 7'h7f);
      add_slots(1'b1, 1'b0, 1, 1'b0, '0);
      add_slots(1'b0, 1'b0, 39, 1'b0, '0);
      add_slots(1'b0, 1'b1, 32, 1'b0, '0);
      add_slots(1'b0, 1'b0, 8, 1'b0, '0);
      add_slots(1'b0, 1'b1, 1, 1'b1, mk_rsp(1'b1, 1'b0, 1'b0, 1'b0));
      // 31 clamps to the maximum burst
      add_csr(i2cmbr_pkg::CSR_READ_COUNT, 7'h7f);
      add_csr(i2cmbr_pkg::CSR_SLAVE_ADDRESS, 7'h00);
      add_slots(1'b1, 1'b0, 1, 1'b0, '0);
      add_slots(1'b0, 1'b0, 39, 1'b0, '0);
      add_slots(1'b1, 1'b0, BURST_MAX * 36, 1'b0, '0);
      add_slots(1'b0, 1'b0, 4, 1'b0, '0);
      add_slots(1'b0, 1'b0, 1, 1'b1, mk_rsp(1'b1, 1'b0, 1'b0, 1'b0));
      add_csr(i2cmbr_pkg::CSR_READ_COUNT, 7'd16);
      add_csr(i2cmbr_pkg::CSR_SLAVE_ADDRESS, i2cmbr_pkg::SLAVE_ADDRESS_RST);

      foreach (plan[i]) begin
         if (plan[i].is_csr) csr_write(plan[i].idx, plan[i].wdata);
         else repeat (plan[i].reps)
            send_slot(plan[i].start, plan[i].sda, plan[i].typed, plan[i].want);
      end

      // random bursts; some phases are cut mid-transfer by a register write
      while (sent < ITEM_TARGET) begin
         noisy     = ($urandom_range(0, 6) == 0);
         cut_short = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 2) != 0) csr_write(i2cmbr_pkg::CSR_READ_COUNT, pick_count());
         if ($urandom_range(0, 2) != 0) csr_write(i2cmbr_pkg::CSR_SLAVE_ADDRESS, pick_addr());
         if ($urandom_range(0, 9) == 0)
            csr_write($urandom_range(0, 1) ? CSR_UNMAPPED_LO : CSR_UNMAPPED_HI,
                      7'($urandom_range(0, 127)));
         burst = $urandom_range(30, 150);
         for (int k = 0; k < burst || (!cut_short && ph != i2cmbr_pkg::PH_IDLE); k++) begin
            if (noisy)                         start = 1'($urandom_range(0, 1));
            else if (ph == i2cmbr_pkg::PH_IDLE) start = ($urandom_range(0, 2) == 0);
            else                               start = ($urandom_range(0, 3) == 0);
            sda = 1'($urandom_range(0, 1));
            if (ph == i2cmbr_pkg::PH_AACK && slot == i2cmbr_pkg::SLOT_SAMPLE)
               sda = noisy ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) == 0);
            send_slot(start, sda, 1'b0, '0);
         end
      end

      hold_req();
      while (pending.size() != 0) @(posedge clock);
      repeat (END_SETTLE) @(posedge clock);
      $display("tb: %0d slots sent, %0d beats checked, %0d transfers, %0d address nacks",
               sent, beats, txn_count, nack_count);
      $display("tb: %0d bytes received, %0d register writes", bytes_rx, csr_writes);
      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
